// File: rtl/core/pat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pat_pkg;

  localparam int unsigned LfsrW = 16;
  localparam logic [LfsrW-1:0] LfsrTaps = 16'hB400;
  localparam logic [LfsrW-1:0] LfsrOne = 16'h0001;

  localparam logic OpRead = 1'b0;
  localparam logic OpWrite = 1'b1;

  // Galois step: shift right, fold the taps back in when a one drops out
  function automatic logic [LfsrW-1:0] lfsr_step(input logic [LfsrW-1:0] v);
    logic [LfsrW-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LfsrTaps;
    end
    return s;
  endfunction

  // A zero seed would lock the register up, so it loads as one
  function automatic logic [LfsrW-1:0] lfsr_seed_fix(input logic [LfsrW-1:0] v);
    return (v == '0) ? LfsrOne : v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/paged_address_translator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Fields
// s_axis   | in  | tuser: opcode; tdata: vaddr, write_data
// m_axis   | out | tdata: read_data, fault, frame_used, wrote_back
// cfg      | in  | lfsr_seed, written on cfg_we_i
//
// A page table hit passes the page table read, the byte store access and the result
// register, which waits while the previous result is not taken. A miss adds a frame
// table read per random pick, an owner page table read for each pick that lands on a
// live frame, and a write of the new mapping. After reset a clearing pass over
// max(PAGE_COUNT, NUM_FRAMES) entries zeroes the page, frame and dirty tables; one
// item is in flight at a time, and it may be taken while the previous result waits.
// PAGE_BYTES, PAGE_COUNT and NUM_FRAMES must be powers of two; the block itself does not check this.

module paged_address_translator
  import pat_pkg::*;
#(
  parameter int unsigned PAGE_BYTES  = 256,
  parameter int unsigned PAGE_COUNT  = 256,
  parameter int unsigned NUM_FRAMES  = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,     // lfsr_seed

  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [23:0] s_tdata_i,       // [15:0] vaddr, [23:16] write_data
  input  wire logic        s_tuser_i,       // opcode

  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [23:0]      m_tdata_o        // [7:0] read_data, [8] fault,
                                            // [16:9] frame_used, [17] wrote_back
);

  localparam int unsigned OW = $clog2(PAGE_BYTES);
  localparam int unsigned PW = $clog2(PAGE_COUNT);
  localparam int unsigned FW = $clog2(NUM_FRAMES);
  localparam int unsigned BW = FW + OW;
  localparam int unsigned MaxDepth = (PAGE_COUNT > NUM_FRAMES) ? PAGE_COUNT : NUM_FRAMES;
  localparam int unsigned CW = $clog2(MaxDepth);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PT    = 3'd2;
  localparam logic [2:0] S_FT    = 3'd3;
  localparam logic [2:0] S_OWN   = 3'd4;
  localparam logic [2:0] S_MAP   = 3'd5;
  localparam logic [2:0] S_MEM   = 3'd6;
  localparam logic [2:0] S_RES   = 3'd7;

  // ---------------------------------------------------------------- state
  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    clr_q, clr_d;
  logic [LfsrW-1:0] lfsr_q, lfsr_d;
  logic [FW:0]      vcnt_q, vcnt_d;
  logic             out_valid_q, out_valid_d;
  logic [23:0]      out_data_q, out_data_d;

  logic             op_q, op_d;
  logic [PW-1:0]    page_q, page_d;
  logic [OW-1:0]    off_q, off_d;
  logic [7:0]       wdata_q, wdata_d;
  logic             free_q, free_d;
  logic [FW-1:0]    pick_q, pick_d;
  logic [FW-1:0]    frame_q, frame_d;
  logic [PW-1:0]    owner_q, owner_d;
  logic             fvalid_q, fvalid_d;
  logic             fdirty_q, fdirty_d;
  logic             fault_q, fault_d;
  logic             wb_q, wb_d;

  // ---------------------------------------------------------------- memories
  // page table entry: {valid, frame}
  logic [FW:0]   pt_mem [PAGE_COUNT];
  logic          pt_we;
  logic [PW-1:0] pt_waddr, pt_raddr;
  logic [FW:0]   pt_wdata, pt_rdata_q;

  // frame table entry: {valid, owner}
  logic [PW:0]   ft_mem [NUM_FRAMES];
  logic          ft_we;
  logic [FW-1:0] ft_waddr, ft_raddr;
  logic [PW:0]   ft_wdata, ft_rdata_q;

  logic          dt_mem [NUM_FRAMES];
  logic          dt_we, dt_wdata, dt_rdata_q;
  logic [FW-1:0] dt_waddr;

  logic [7:0]    bs_mem [NUM_FRAMES * PAGE_BYTES];
  logic          bs_we;
  logic [BW-1:0] bs_addr;
  logic [7:0]    bs_rdata_q;

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    pt_rdata_q <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ft_we) begin
      ft_mem[ft_waddr] <= ft_wdata;
    end
    ft_rdata_q <= ft_mem[ft_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dt_we) begin
      dt_mem[dt_waddr] <= dt_wdata;
    end
    dt_rdata_q <= dt_mem[ft_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (bs_we) begin
      bs_mem[bs_addr] <= wdata_q;
    end else begin
      bs_rdata_q <= bs_mem[bs_addr];
    end
  end

  // ---------------------------------------------------------------- control
  logic [16+PW-1:0] va_ext;
  logic [LfsrW-1:0] lfsr_next;
  logic [FW+7:0]    frame_ext;
  logic             in_xfer;

  assign in_xfer    = s_tvalid_i && s_tready_o;
  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign va_ext     = {{PW{1'b0}}, s_tdata_i[15:0]};
  assign lfsr_next  = lfsr_step(lfsr_q);
  assign frame_ext  = {8'd0, frame_q};

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    lfsr_d      = lfsr_q;
    vcnt_d      = vcnt_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    op_d        = op_q;
    page_d      = page_q;
    off_d       = off_q;
    wdata_d     = wdata_q;
    free_d      = free_q;
    pick_d      = pick_q;
    frame_d     = frame_q;
    owner_d     = owner_q;
    fvalid_d    = fvalid_q;
    fdirty_d    = fdirty_q;
    fault_d     = fault_q;
    wb_d        = wb_q;

    pt_we    = 1'b0;
    pt_waddr = page_q;
    pt_wdata = {1'b1, pick_q};
    pt_raddr = va_ext[OW +: PW];
    ft_we    = 1'b0;
    ft_waddr = pick_q;
    ft_wdata = {1'b1, page_q};
    ft_raddr = lfsr_next[FW-1:0];
    dt_we    = 1'b0;
    dt_waddr = pick_q;
    dt_wdata = 1'b0;
    bs_we    = 1'b0;
    bs_addr  = {frame_q, off_q};

    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clr_q[PW-1:0];
        pt_wdata = '0;
        ft_we    = 1'b1;
        ft_waddr = clr_q[FW-1:0];
        ft_wdata = '0;
        dt_we    = 1'b1;
        dt_waddr = clr_q[FW-1:0];
        clr_d    = clr_q + 1'b1;
        if (clr_q == CW'(MaxDepth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          op_d    = s_tuser_i;
          page_d  = va_ext[OW +: PW];
          off_d   = s_tdata_i[OW-1:0];
          wdata_d = s_tdata_i[23:16];
          fault_d = 1'b0;
          wb_d    = 1'b0;
          state_d = S_PT;
        end
      end
      S_PT: begin
        if (pt_rdata_q[FW]) begin
          frame_d = pt_rdata_q[FW-1:0];
          state_d = S_MEM;
        end else begin
          fault_d = 1'b1;
          free_d  = (vcnt_q < (FW+1)'(NUM_FRAMES));
          lfsr_d  = lfsr_next;
          pick_d  = lfsr_next[FW-1:0];
          state_d = S_FT;
        end
      end
      S_FT: begin
        fvalid_d = ft_rdata_q[PW];
        fdirty_d = dt_rdata_q;
        owner_d  = ft_rdata_q[PW-1:0];
        pt_raddr = ft_rdata_q[PW-1:0];
        state_d  = ft_rdata_q[PW] ? S_OWN : S_MAP;
      end
      S_OWN: begin
        if (free_q && pt_rdata_q[FW]) begin
          // frame still holds a live page, try another
          lfsr_d  = lfsr_next;
          pick_d  = lfsr_next[FW-1:0];
          state_d = S_FT;
        end else begin
          if (pt_rdata_q[FW] && (pt_rdata_q[FW-1:0] == pick_q)) begin
            pt_we    = 1'b1;
            pt_waddr = owner_q;
            pt_wdata = '0;
          end
          wb_d    = fdirty_q;
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        pt_we   = 1'b1;
        ft_we   = 1'b1;
        dt_we   = 1'b1;
        frame_d = pick_q;
        if (!fvalid_q) begin
          vcnt_d = vcnt_q + 1'b1;
        end
        state_d = S_MEM;
      end
      S_MEM: begin
        bs_we = (op_q == OpWrite);
        if (op_q == OpWrite) begin
          dt_we    = 1'b1;
          dt_waddr = frame_q;
          dt_wdata = 1'b1;
        end
        state_d = S_RES;
      end
      S_RES: begin
        if (!out_valid_q || m_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {6'd0, wb_q, frame_ext[7:0], fault_q,
                         (op_q == OpWrite) ? 8'd0 : bs_rdata_q};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      lfsr_d = lfsr_seed_fix(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      lfsr_q      <= LfsrOne;
      vcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      lfsr_q      <= lfsr_d;
      vcnt_q      <= vcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    op_q       <= op_d;
    page_q     <= page_d;
    off_q      <= off_d;
    wdata_q    <= wdata_d;
    free_q     <= free_d;
    pick_q     <= pick_d;
    frame_q    <= frame_d;
    owner_q    <= owner_d;
    fvalid_q   <= fvalid_d;
    fdirty_q   <= fdirty_d;
    fault_q    <= fault_d;
    wb_q       <= wb_d;
  end

  // ---------------------------------------------------------------- checks
  a_no_xfer_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_tready_o)
    else $error("input transfer possible during clearing pass");

  a_vcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q <= (FW+1)'(NUM_FRAMES))
    else $error("live frame count overflow");

  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0)
    else $error("random picker locked at zero");

  a_map_then_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAP) |=> (state_q == S_MEM) && fault_q)
    else $error("mapping not followed by the byte access");

  a_result_after_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RES) && (!out_valid_q || m_tready_i) |=> m_tvalid_o)
    else $error("finished item gave no result");

endmodule

`default_nettype wire
